// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// SHA-256 stream hasher: shared types, round constants and initial hash.
// No dependencies; imported by every module of the block.
package sha256_pkg;

  typedef logic [7:0][31:0] digest_t;

  typedef enum logic [1:0] {
    SRC_IN    = 2'd0,
    SRC_PAD80 = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_e;

  typedef struct packed {
    logic      shift;
    byte_src_e src;
    logic [2:0] len_sel;
    logic      count_byte;
    logic      load_work;
    logic      round;
    logic [5:0] rnd_idx;
    logic      hash_upd;
    logic      digest;
  } sha_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // word 0 sits at index 0
  localparam digest_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/sha256_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the SHA-256 hasher: one message byte per transfer.
// No dependencies.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

// ===== rtl/sha256_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the SHA-256 hasher: one digest word per transfer.
// No dependencies.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// SHA-256 stream hasher top level: controller, datapath and digest buffer.
// Depends on sha256_pkg, sha256_in_if, sha256_out_if and all sha256_* modules.
//
//   channel  dir  payload                                 transfer
//   in_i     in   data_byte, byte_present, message_end    valid & ready
//   out_o    out  digest_word, word_index, last_word      valid & ready
//
// A byte that does not fill the block is shifted in as it is accepted; the 64th byte
// is followed by the 64 rounds and the hash update, during which no input is taken,
// as the single round unit and the byte-wide block loader work on one block store.
// Message end: padding is shifted in a byte a cycle up to the block end, then
// 64 rounds (twice when the length spills into a second block), then the digest load.
// Reset loads the initial hash at once; the block store needs no clearing.
// The eight digest words wait in their own buffer; the next message is taken
// meanwhile and stalls only if its digest is due before the buffer has drained.
module sha256_stream_hasher import sha256_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  sha_cmd_t cmd;
  digest_t  digest;
  logic     out_busy;

  sha256_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_present_i (in_i.byte_present),
    .in_end_i     (in_i.message_end),
    .in_ready_o   (in_i.ready),
    .out_busy_i   (out_busy),
    .cmd_o        (cmd)
  );

  sha256_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (in_i.data_byte),
    .digest_o    (digest)
  );

  sha256_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (cmd.digest),
    .digest_i (digest),
    .busy_o   (out_busy),
    .out_o    (out_o)
  );

  a_digest_into_free_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.digest |-> !out_busy)
    else $error("digest loaded while buffer busy");

  a_digest_shows_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.digest |=> (out_o.valid && out_o.word_index == 3'd0))
    else $error("digest load not followed by word 0");

  a_last_word_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> !out_o.valid)
    else $error("buffer still valid after last word");

  a_no_input_during_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> (!in_i.ready && !cmd.shift))
    else $error("input or load during compression");

endmodule

// ===== rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// SHA-256 controller: byte position, padding sequence and round counter.
// Depends on sha256_pkg; drives the datapath through sha_cmd_t.
module sha256_ctrl import sha256_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_present_i,
  input  logic     in_end_i,
  output logic     in_ready_o,
  input  logic     out_busy_i,
  output sha_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DIGEST = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] rnd_q, rnd_d;
  logic       closing_q, closing_d;
  logic       p80_q, p80_d;
  logic       lenph_q, lenph_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    rnd_d     = rnd_q;
    closing_d = closing_q;
    p80_d     = p80_q;
    lenph_d   = lenph_q;
    cmd_o     = '0;
    cmd_o.src     = SRC_IN;
    cmd_o.len_sel = pos_q[2:0];
    cmd_o.rnd_idx = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.shift      = in_present_i;
          cmd_o.count_byte = in_present_i;
          pos_d = pos_q + {5'd0, in_present_i};
          if (in_present_i && pos_q == 6'd63) begin
            cmd_o.load_work = 1'b1;
            closing_d = in_end_i;
            rnd_d     = '0;
            state_d   = ST_ROUND;
          end else if (in_end_i) begin
            closing_d = 1'b1;
            state_d   = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.shift = 1'b1;
        if (!p80_q) begin
          cmd_o.src = SRC_PAD80;
          p80_d   = 1'b1;
          lenph_d = (pos_q < 6'd56);
        end else if (lenph_q && pos_q[5:3] == 3'b111) begin
          cmd_o.src = SRC_LEN;
        end else begin
          cmd_o.src = SRC_ZERO;
        end
        pos_d = pos_q + 6'd1;
        if (pos_q == 6'd63) begin
          cmd_o.load_work = 1'b1;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = (closing_q && lenph_q) ? ST_DIGEST : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.hash_upd = 1'b1;
        if (closing_q) begin
          if (p80_q) begin
            lenph_d = 1'b1;
          end
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIGEST: begin
        if (!out_busy_i) begin
          cmd_o.digest = 1'b1;
          closing_d = 1'b0;
          p80_d     = 1'b0;
          lenph_d   = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      rnd_q     <= '0;
      closing_q <= 1'b0;
      p80_q     <= 1'b0;
      lenph_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      rnd_q     <= rnd_d;
      closing_q <= closing_d;
      p80_q     <= p80_d;
      lenph_q   <= lenph_d;
    end
  end

endmodule

// ===== rtl/sha256_dp.sv =====
`timescale 1ns / 1ps
// SHA-256 datapath: block shift register with message schedule, one round
// per cycle, hash state and bit length. Depends on sha256_pkg.
module sha256_dp import sha256_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sha_cmd_t   cmd_i,
  input  logic [7:0] data_byte_i,
  output digest_t    digest_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  logic [511:0] blk_q, blk_d;
  digest_t      wv_q, wv_d;
  digest_t      hash_q, hash_d;
  logic [63:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, s0, s1, new_w;
  logic [31:0]  big0, big1, ch, maj, t1, t2;

  // word 0 of the window is the top of blk_q
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];

  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign new_w = w0 + s0 + w9 + s1;

  assign big1 = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
  assign ch   = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign t1   = wv_q[7] + big1 + ch + ROUND_K[cmd_i.rnd_idx] + w0;
  assign big0 = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
  assign maj  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_o[i] = hash_q[i] + wv_q[i];
    end
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_IN:    byte_in = data_byte_i;
      SRC_PAD80: byte_in = PAD_BYTE;
      SRC_ZERO:  byte_in = 8'h00;
      SRC_LEN:   byte_in = bit_cnt_q[{~cmd_i.len_sel, 3'b000} +: 8];
      default:   byte_in = 8'h00;
    endcase
  end

  always_comb begin
    blk_d = blk_q;
    wv_d  = wv_q;
    if (cmd_i.shift) begin
      blk_d = {blk_q[503:0], byte_in};
    end else if (cmd_i.round) begin
      blk_d = {blk_q[479:0], new_w};
    end
    if (cmd_i.load_work) begin
      wv_d = hash_q;
    end else if (cmd_i.round) begin
      wv_d[7] = wv_q[6];
      wv_d[6] = wv_q[5];
      wv_d[5] = wv_q[4];
      wv_d[4] = wv_q[3] + t1;
      wv_d[3] = wv_q[2];
      wv_d[2] = wv_q[1];
      wv_d[1] = wv_q[0];
      wv_d[0] = t1 + t2;
    end
  end

  always_comb begin
    hash_d    = hash_q;
    bit_cnt_d = bit_cnt_q;
    if (cmd_i.count_byte) begin
      bit_cnt_d = bit_cnt_q + 64'd8;
    end
    if (cmd_i.hash_upd) begin
      hash_d = digest_o;
    end
    if (cmd_i.digest) begin
      hash_d    = HASH_IV;
      bit_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    wv_q  <= wv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= HASH_IV;
      bit_cnt_q <= '0;
    end else begin
      hash_q    <= hash_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

endmodule

// ===== rtl/sha256_outbuf.sv =====
`timescale 1ns / 1ps
// SHA-256 digest buffer: holds the eight words and sends them one per transfer.
// Depends on sha256_pkg and sha256_out_if.
module sha256_outbuf import sha256_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  digest_t digest_i,
  output logic    busy_o,
  sha256_out_if.source out_o
);

  digest_t    dig_q, dig_d;
  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       xfer;

  assign xfer              = valid_q && out_o.ready;
  assign busy_o            = valid_q;
  assign out_o.valid       = valid_q;
  assign out_o.digest_word = dig_q[0];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    dig_d   = dig_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      dig_d   = digest_i;
      idx_d   = '0;
      valid_d = 1'b1;
    end else if (xfer) begin
      for (int i = 0; i < 7; i++) begin
        dig_d[i] = dig_q[i + 1];
      end
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

endmodule
